// File: design/i2cms_pkg.sv
// i2cms_pkg: shared types and constants of the i2c master transaction sequencer
// request and result payloads, sequencer phases, status codes of the i2c core
// no dependencies
package i2cms_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TX    = 3'd3,
    PH_RX    = 3'd4
  } phase_e;

  typedef enum logic {
    REQ_BEGIN = 1'b0,
    REQ_EVENT = 1'b1
  } req_type_e;

  // status codes reported by the core
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  typedef struct packed {
    logic       req_type;
    logic [6:0] target_addr;
    logic       direction;
    logic [7:0] byte_count;
    logic       stop_at_end;
    logic [7:0] core_status;
    logic [7:0] core_data;
    logic [7:0] tx_byte;
  } req_t;

  typedef struct packed {
    logic       cmd_start;
    logic       cmd_stop;
    logic       ack_next;
    logic       load_valid;
    logic [7:0] load_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       success;
    logic       acked;
    logic [7:0] bytes_done;
    logic [7:0] end_status;
  } res_t;

endpackage

// File: design/i2cms_if.sv
// i2cms_req_if / i2cms_res_if: valid-ready channels of the sequencer
// depends on i2cms_pkg for the payload types
interface i2cms_req_if import i2cms_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cms_res_if import i2cms_pkg::*; ();
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/i2cms_fsm.sv
// i2cms_fsm: transaction state and per-request decision logic
// state advances on fire_i; res_o is the combinational result for req_i
// depends on i2cms_pkg
module i2cms_fsm import i2cms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  req_t req_i,
  output res_t res_o
);

  phase_e     phase_q, phase_d;
  logic       is_read_q, is_read_d;
  logic       want_stop_q, want_stop_d;
  logic [6:0] peer_addr_q, peer_addr_d;
  logic [7:0] total_q, total_d;
  logic [7:0] done_q, done_d;

  logic [7:0] done_inc;
  logic [8:0] done_inc_w;
  logic       start_ok, addr_ok, tx_ok, rx_ok;
  logic       rx_last, rx_more;

  assign done_inc   = done_q + 8'd1;
  assign done_inc_w = {1'b0, done_q} + 9'd1;
  assign rx_last    = done_inc_w >= {1'b0, total_q};
  // ack for the byte after this one, counted after the wrap of the byte counter
  assign rx_more    = ({1'b0, done_inc} + 9'd1) < {1'b0, total_q};

  assign start_ok = (req_i.core_status == ST_START) || (req_i.core_status == ST_RESTART);
  assign addr_ok  = req_i.core_status == (is_read_q ? ST_ADDR_R_ACK : ST_ADDR_W_ACK);
  assign tx_ok    = req_i.core_status == ST_DATA_W_ACK;
  assign rx_ok    = (req_i.core_status == ST_DATA_R_ACK) ||
                    (req_i.core_status == ST_DATA_R_NACK);

  // next state
  always_comb begin
    phase_d     = phase_q;
    is_read_d   = is_read_q;
    want_stop_d = want_stop_q;
    peer_addr_d = peer_addr_q;
    total_d     = total_q;
    done_d      = done_q;
    if (req_i.req_type == REQ_BEGIN) begin
      peer_addr_d = req_i.target_addr;
      is_read_d   = req_i.direction;
      total_d     = req_i.byte_count;
      want_stop_d = req_i.stop_at_end;
      done_d      = 8'd0;
      phase_d     = PH_START;
    end else begin
      case (phase_q)
        PH_START: begin
          phase_d = start_ok ? PH_ADDR : PH_IDLE;
        end
        PH_ADDR: begin
          if (!addr_ok || total_q == 8'd0) begin
            phase_d = PH_IDLE;
          end else begin
            phase_d = is_read_q ? PH_RX : PH_TX;
          end
        end
        PH_TX: begin
          if (tx_ok) begin
            done_d = done_inc;
            if (done_inc >= total_q) begin
              phase_d = PH_IDLE;
            end
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_RX: begin
          if (rx_ok) begin
            done_d = done_inc;
            if (rx_last) begin
              phase_d = PH_IDLE;
            end
          end else begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    res_o = '0;
    if (req_i.req_type == REQ_BEGIN) begin
      res_o.cmd_start = 1'b1;
    end else begin
      if (phase_q != PH_IDLE) begin
        res_o.end_status = req_i.core_status;
      end
      case (phase_q)
        PH_START: begin
          if (start_ok) begin
            res_o.acked      = 1'b1;
            res_o.load_valid = 1'b1;
            res_o.load_byte  = {peer_addr_q, is_read_q};
          end else begin
            res_o.done_res = 1'b1;
          end
        end
        PH_ADDR: begin
          if (addr_ok) begin
            res_o.acked = 1'b1;
            if (total_q == 8'd0) begin
              res_o.done_res = 1'b1;
              res_o.success  = 1'b1;
              res_o.cmd_stop = want_stop_q;
            end else if (is_read_q) begin
              res_o.ack_next = total_q > 8'd1;
            end else begin
              res_o.load_valid = 1'b1;
              res_o.load_byte  = req_i.tx_byte;
            end
          end else begin
            res_o.done_res = 1'b1;
          end
        end
        PH_TX: begin
          if (tx_ok) begin
            res_o.acked = 1'b1;
            if (done_inc >= total_q) begin
              res_o.done_res = 1'b1;
              res_o.success  = 1'b1;
              res_o.cmd_stop = want_stop_q;
            end else begin
              res_o.load_valid = 1'b1;
              res_o.load_byte  = req_i.tx_byte;
            end
          end else begin
            res_o.done_res = 1'b1;
          end
        end
        PH_RX: begin
          if (rx_ok) begin
            res_o.acked    = !rx_last;
            res_o.rx_valid = 1'b1;
            res_o.rx_byte  = req_i.core_data;
            if (rx_last) begin
              res_o.done_res = 1'b1;
              res_o.success  = 1'b1;
              res_o.cmd_stop = want_stop_q;
            end else begin
              res_o.ack_next = rx_more;
            end
          end else begin
            res_o.done_res = 1'b1;
          end
        end
        default: begin
          res_o.end_status = 8'd0;
        end
      endcase
    end
    res_o.bytes_done = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      is_read_q   <= 1'b0;
      want_stop_q <= 1'b0;
      peer_addr_q <= 7'd0;
      total_q     <= 8'd0;
      done_q      <= 8'd0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      is_read_q   <= is_read_d;
      want_stop_q <= want_stop_d;
      peer_addr_q <= peer_addr_d;
      total_q     <= total_d;
      done_q      <= done_d;
    end
  end

endmodule

// File: design/i2c_master_transaction_sequencer.sv
// i2c_master_transaction_sequencer: top level with request and result registers
// depends on i2cms_pkg, i2cms_req_if, i2cms_res_if and i2cms_fsm
//
// Usage: req_i carries begin requests (address, direction, length, stop choice)
// and core event requests (status, received byte, next byte to send). Every
// request gives exactly one result on res_o, in order: start/stop commands,
// data-register load, ack bit for the next read byte, received byte and the
// transaction outcome.
// A result passes through the request register and then the result register:
// the request register loads at the accepting edge, then the decision logic
// writes the result register once that register is free, so a stall on res_o
// can come between them. Throughput is one request per cycle while res_o is
// ready; the decision logic steps whenever the result register is free or drained.
// Reset clears both stage valids and returns the sequencer to idle with a zero
// byte count. When res_o stalls, the result holds, then the request register
// fills and req_i.ready drops until the result is taken.
module i2c_master_transaction_sequencer import i2cms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  i2cms_req_if.sink   req_i,
  i2cms_res_if.source res_o
);

  logic in_valid_q;
  req_t in_q;
  logic out_valid_q;
  res_t out_q;
  res_t res_d;
  logic out_free;
  logic fire;
  logic take;

  assign out_free    = !out_valid_q || res_o.ready;
  assign fire        = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || fire;
  assign take        = req_i.valid && req_i.ready;

  i2cms_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= req_i.payload;
    end
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

endmodule
